### design/pfs_pkg.sv
package pfs_pkg;

  localparam logic [1:0] OP_VBUS    = 2'd0;
  localparam logic [1:0] OP_PROTECT = 2'd1;
  localparam logic [1:0] OP_RECOVER = 2'd2;

  localparam logic [1:0] MODE_DISCHG = 2'd1;
  localparam logic [1:0] MODE_CHARGE = 2'd2;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_BUS_OV_MV    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BAT_LOW_MV   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BAT_LOW_TCK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BUS_UV_MV    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BUS_UV_TCK   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BAT_RECOV_MV = 3'd5;

  localparam logic [15:0] RST_BUS_OV_MV    = 16'd20000;
  localparam logic [15:0] RST_BAT_LOW_MV   = 16'd3000;
  localparam logic [3:0]  RST_BAT_LOW_TCK  = 4'd10;
  localparam logic [15:0] RST_BUS_UV_MV    = 16'd4400;
  localparam logic [2:0]  RST_BUS_UV_TCK   = 3'd5;
  localparam logic [15:0] RST_BAT_RECOV_MV = 16'd3300;

  localparam logic [10:0] BIT_OVP     = 11'h010;
  localparam logic [10:0] BIT_DEAD    = 11'h100;
  localparam logic [10:0] BIT_UV      = 11'h200;
  localparam logic [10:0] BIT_THERMAL = 11'h400;
  localparam logic [10:0] LOCK_MASK   = 11'h7D5;

  typedef struct packed {
    logic [15:0] bus_ov_mv;
    logic [15:0] bat_low_mv;
    logic [3:0]  bat_low_ticks;
    logic [15:0] bus_uv_mv;
    logic [2:0]  bus_uv_ticks;
    logic [15:0] bat_recover_mv;
  } pfs_cfg_t;

  typedef struct packed {
    logic [3:0]  low_battery_count;
    logic [2:0]  undervoltage_count;
    logic        undervoltage_flag;
    logic        lock_held;
    logic        dead_mark;
    logic        dead_sticky;
    logic [10:0] last_status;
  } pfs_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] bus_mv;
    logic [15:0] battery_mv;
    logic [7:0]  chip_faults;
    logic        thermal_lock;
    logic [1:0]  work_mode;
    logic        sink_attached;
    logic        chip_dead_battery;
  } pfs_item_t;

  typedef struct packed {
    logic [10:0] status_word;
    logic        locked;
    logic        lock_action;
    logic        unlock_action;
    logic        dead_battery;
    logic        battery_dead_latched;
    logic        restart_charge;
    logic        undervoltage_pending;
  } pfs_result_t;

endpackage

### design/pfs_core.sv
module pfs_core (
  input  pfs_pkg::pfs_cfg_t    cfg,
  input  pfs_pkg::pfs_state_t  st,
  input  pfs_pkg::pfs_item_t   item,
  output pfs_pkg::pfs_state_t  st_nxt,
  output pfs_pkg::pfs_result_t res
);
  import pfs_pkg::*;

  logic [10:0] status;
  logic [3:0]  lb_inc;
  logic [2:0]  uv_inc;
  logic        lock_act;
  logic        unlock_act;
  logic        restart;

  assign lb_inc = st.low_battery_count + 4'd1;
  assign uv_inc = st.undervoltage_count + 3'd1;

  always_comb begin
    st_nxt     = st;
    status     = {3'b000, item.chip_faults};
    lock_act   = 1'b0;
    unlock_act = 1'b0;
    restart    = 1'b0;
    unique case (item.op)
      OP_VBUS: begin
        if (item.work_mode == MODE_DISCHG && item.sink_attached) begin
          if (item.bus_mv < cfg.bus_uv_mv) begin
            st_nxt.undervoltage_count = uv_inc;
            if (uv_inc >= cfg.bus_uv_ticks) begin
              st_nxt.undervoltage_count = 3'd0;
              st_nxt.undervoltage_flag  = 1'b1;
            end
          end else begin
            st_nxt.undervoltage_count = 3'd0;
          end
        end else begin
          st_nxt.undervoltage_count = 3'd0;
          st_nxt.undervoltage_flag  = 1'b0;
        end
      end
      OP_PROTECT: begin
        if (item.bus_mv > cfg.bus_ov_mv) begin
          status = status | BIT_OVP;
        end
        if (item.thermal_lock) begin
          status = status | BIT_THERMAL;
        end
        if (item.battery_mv < cfg.bat_low_mv) begin
          st_nxt.low_battery_count = lb_inc;
          if (lb_inc >= cfg.bat_low_ticks) begin
            if (item.work_mode != MODE_CHARGE) begin
              st_nxt.dead_sticky = 1'b1;
              status = status | BIT_DEAD;
            end else if (!st.dead_mark) begin
              restart = 1'b1;
            end
            st_nxt.dead_mark         = 1'b1;
            st_nxt.low_battery_count = 4'd0;
          end
        end else begin
          st_nxt.low_battery_count = 4'd0;
        end
        if (st.undervoltage_flag) begin
          st_nxt.undervoltage_flag = 1'b0;
          status = status | BIT_UV;
        end
        if (status != 11'd0) begin
          if ((status & LOCK_MASK) != 11'd0) begin
            lock_act         = 1'b1;
            st_nxt.lock_held = 1'b1;
          end
        end else if (st.lock_held) begin
          st_nxt.lock_held = 1'b0;
          unlock_act       = 1'b1;
        end
        st_nxt.last_status = status;
      end
      OP_RECOVER: begin
        if (item.battery_mv > cfg.bat_recover_mv && !item.chip_dead_battery
            && st.dead_mark) begin
          st_nxt.dead_mark = 1'b0;
          restart          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status_word          = st_nxt.last_status;
    res.locked               = st_nxt.lock_held;
    res.lock_action          = lock_act;
    res.unlock_action        = unlock_act;
    res.dead_battery         = st_nxt.dead_mark;
    res.battery_dead_latched = st_nxt.dead_sticky;
    res.restart_charge       = restart;
    res.undervoltage_pending = st_nxt.undervoltage_flag;
  end

endmodule

### design/power_fault_supervisor_unit.sv
// Fault supervisor for a buck-boost power path. Each transfer on the input
// channel is one tick (vbus sample, protection, battery recovery or no-op)
// and yields exactly one result transfer. A tick is captured in an input
// register; its result is computed combinationally from that register and
// the supervisor state and written into a two-entry output queue once the
// queue has room, so one tick is accepted every cycle while the output side
// keeps up. The input stalls only when the output queue is full. Configuration
// registers are always ready and should be written only while the unit is idle.
module power_fault_supervisor_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [15:0]                    in_bus_mv,
  input  logic [15:0]                    in_battery_mv,
  input  logic [7:0]                     in_chip_faults,
  input  logic                           in_thermal_lock,
  input  logic [1:0]                     in_work_mode,
  input  logic                           in_sink_attached,
  input  logic                           in_chip_dead_battery,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [10:0]                    out_status_word,
  output logic                           out_locked,
  output logic                           out_lock_action,
  output logic                           out_unlock_action,
  output logic                           out_dead_battery,
  output logic                           out_battery_dead_latched,
  output logic                           out_restart_charge,
  output logic                           out_undervoltage_pending,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfs_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [15:0]                    cfg_data
);
  import pfs_pkg::*;

  pfs_cfg_t    cfg_r;
  pfs_state_t  st_r;
  pfs_state_t  st_nxt;
  pfs_item_t   item_r;
  pfs_result_t res;
  logic        s1_valid_r;
  logic        in_xfer;
  logic        out_xfer;
  logic        adv;
  logic        q_full;
  pfs_result_t q_mem_r [2];
  logic        q_wr_r;
  logic        q_rd_r;
  logic [1:0]  q_cnt_r;
  logic [1:0]  q_cnt_nxt;

  assign cfg_ready = 1'b1;
  assign q_full    = (q_cnt_r == 2'd2);
  assign adv       = s1_valid_r && !q_full;
  assign in_stall  = s1_valid_r && q_full;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (adv && !out_xfer) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!adv && out_xfer) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  pfs_core u_core (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_ov_mv      <= RST_BUS_OV_MV;
      cfg_r.bat_low_mv     <= RST_BAT_LOW_MV;
      cfg_r.bat_low_ticks  <= RST_BAT_LOW_TCK;
      cfg_r.bus_uv_mv      <= RST_BUS_UV_MV;
      cfg_r.bus_uv_ticks   <= RST_BUS_UV_TCK;
      cfg_r.bat_recover_mv <= RST_BAT_RECOV_MV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUS_OV_MV:    cfg_r.bus_ov_mv      <= cfg_data;
        REG_BAT_LOW_MV:   cfg_r.bat_low_mv     <= cfg_data;
        REG_BAT_LOW_TCK:  cfg_r.bat_low_ticks  <= cfg_data[3:0];
        REG_BUS_UV_MV:    cfg_r.bus_uv_mv      <= cfg_data;
        REG_BUS_UV_TCK:   cfg_r.bus_uv_ticks   <= cfg_data[2:0];
        REG_BAT_RECOV_MV: cfg_r.bat_recover_mv <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      s1_valid_r <= 1'b0;
      q_wr_r     <= 1'b0;
      q_rd_r     <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      if (adv) begin
        st_r   <= st_nxt;
        q_wr_r <= ~q_wr_r;
      end
      if (out_xfer) begin
        q_rd_r <= ~q_rd_r;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.op                <= in_op;
      item_r.bus_mv            <= in_bus_mv;
      item_r.battery_mv        <= in_battery_mv;
      item_r.chip_faults       <= in_chip_faults;
      item_r.thermal_lock      <= in_thermal_lock;
      item_r.work_mode         <= in_work_mode;
      item_r.sink_attached     <= in_sink_attached;
      item_r.chip_dead_battery <= in_chip_dead_battery;
    end
    if (adv) begin
      q_mem_r[q_wr_r] <= res;
    end
  end

  pfs_result_t q_head;
  assign q_head = q_mem_r[q_rd_r];

  assign out_status_word          = q_head.status_word;
  assign out_locked               = q_head.locked;
  assign out_lock_action          = q_head.lock_action;
  assign out_unlock_action        = q_head.unlock_action;
  assign out_dead_battery         = q_head.dead_battery;
  assign out_battery_dead_latched = q_head.battery_dead_latched;
  assign out_restart_charge       = q_head.restart_charge;
  assign out_undervoltage_pending = q_head.undervoltage_pending;

endmodule

### sim/power_fault_supervisor_unit_tb.sv
`timescale 1ns / 100ps

module power_fault_supervisor_unit_tb;
  import pfs_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pfs_item_t offer;
  logic out_valid;
  logic out_stall;
  logic [10:0] out_status_word;
  logic out_locked;
  logic out_lock_action;
  logic out_unlock_action;
  logic out_dead_battery;
  logic out_battery_dead_latched;
  logic out_restart_charge;
  logic out_undervoltage_pending;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [15:0] cfg_data;

  pfs_cfg_t regs;
  pfs_state_t shadow;
  pfs_result_t reports_due[$];
  int accepted;
  int fails;
  int hold_cycles;
  bit tx_gaps;
  bit rx_gaps;

  power_fault_supervisor_unit uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_op                    (offer.op),
    .in_bus_mv                (offer.bus_mv),
    .in_battery_mv            (offer.battery_mv),
    .in_chip_faults           (offer.chip_faults),
    .in_thermal_lock          (offer.thermal_lock),
    .in_work_mode             (offer.work_mode),
    .in_sink_attached         (offer.sink_attached),
    .in_chip_dead_battery     (offer.chip_dead_battery),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_status_word          (out_status_word),
    .out_locked               (out_locked),
    .out_lock_action          (out_lock_action),
    .out_unlock_action        (out_unlock_action),
    .out_dead_battery         (out_dead_battery),
    .out_battery_dead_latched (out_battery_dead_latched),
    .out_restart_charge       (out_restart_charge),
    .out_undervoltage_pending (out_undervoltage_pending),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic pfs_result_t supervise_tick(pfs_item_t t);
    pfs_result_t r;
    logic [10:0] status;
    r = '0;
    status = {3'b000, t.chip_faults};
    case (t.op)
      OP_VBUS: begin
        if (t.work_mode == MODE_DISCHG && t.sink_attached) begin
          if (t.bus_mv < regs.bus_uv_mv) begin
            shadow.undervoltage_count = shadow.undervoltage_count + 3'd1;
            if (shadow.undervoltage_count >= regs.bus_uv_ticks) begin
              shadow.undervoltage_count = '0;
              shadow.undervoltage_flag = 1'b1;
            end
          end else begin
            shadow.undervoltage_count = '0;
          end
        end else begin
          shadow.undervoltage_count = '0;
          shadow.undervoltage_flag = 1'b0;
        end
      end
      OP_PROTECT: begin
        if (t.bus_mv > regs.bus_ov_mv) status |= BIT_OVP;
        if (t.thermal_lock) status |= BIT_THERMAL;
        if (t.battery_mv < regs.bat_low_mv) begin
          shadow.low_battery_count = shadow.low_battery_count + 4'd1;
          if (shadow.low_battery_count >= regs.bat_low_ticks) begin
            if (t.work_mode != MODE_CHARGE) begin
              shadow.dead_sticky = 1'b1;
              status |= BIT_DEAD;
            end else if (!shadow.dead_mark) begin
              r.restart_charge = 1'b1;
            end
            shadow.dead_mark = 1'b1;
            shadow.low_battery_count = '0;
          end
        end else begin
          shadow.low_battery_count = '0;
        end
        if (shadow.undervoltage_flag) begin
          shadow.undervoltage_flag = 1'b0;
          status |= BIT_UV;
        end
        if (status != '0) begin
          if ((status & LOCK_MASK) != '0) begin
            r.lock_action = 1'b1;
            shadow.lock_held = 1'b1;
          end
        end else if (shadow.lock_held) begin
          shadow.lock_held = 1'b0;
          r.unlock_action = 1'b1;
        end
        shadow.last_status = status;
      end
      OP_RECOVER: begin
        if (t.battery_mv > regs.bat_recover_mv && !t.chip_dead_battery && shadow.dead_mark) begin
          shadow.dead_mark = 1'b0;
          r.restart_charge = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.status_word = shadow.last_status;
    r.locked = shadow.lock_held;
    r.dead_battery = shadow.dead_mark;
    r.battery_dead_latched = shadow.dead_sticky;
    r.undervoltage_pending = shadow.undervoltage_flag;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      REG_BUS_OV_MV:    regs.bus_ov_mv = data;
      REG_BAT_LOW_MV:   regs.bat_low_mv = data;
      REG_BAT_LOW_TCK:  regs.bat_low_ticks = data[3:0];
      REG_BUS_UV_MV:    regs.bus_uv_mv = data;
      REG_BUS_UV_TCK:   regs.bus_uv_ticks = data[2:0];
      REG_BAT_RECOV_MV: regs.bat_recover_mv = data;
      default: begin
      end
    endcase
  endfunction

  task automatic compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    pfs_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("result transfer with no tick outstanding");
        fails++;
      end else begin
        want = reports_due.pop_front();
        compare_field("status_word", want.status_word, out_status_word);
        compare_field("locked", want.locked, out_locked);
        compare_field("lock_action", want.lock_action, out_lock_action);
        compare_field("unlock_action", want.unlock_action, out_unlock_action);
        compare_field("dead_battery", want.dead_battery, out_dead_battery);
        compare_field("battery_dead_latched", want.battery_dead_latched,
                      out_battery_dead_latched);
        compare_field("restart_charge", want.restart_charge, out_restart_charge);
        compare_field("undervoltage_pending", want.undervoltage_pending,
                      out_undervoltage_pending);
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(pfs_item_t t);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    offer <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reports_due.push_back(supervise_tick(t));
    accepted++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [15:0] ov, logic [15:0] low, logic [15:0] low_ticks,
                              logic [15:0] uv, logic [15:0] uv_ticks, logic [15:0] recover);
    drain();
    write_reg(REG_BUS_OV_MV, ov);
    write_reg(REG_BAT_LOW_MV, low);
    write_reg(REG_BAT_LOW_TCK, low_ticks);
    write_reg(REG_BUS_UV_MV, uv);
    write_reg(REG_BUS_UV_TCK, uv_ticks);
    write_reg(REG_BAT_RECOV_MV, recover);
    cfg_valid <= 1'b0;
  endtask

  function automatic pfs_item_t make_tick(logic [1:0] op, logic [15:0] bus, logic [15:0] bat,
                                          logic [7:0] faults, logic thermal, logic [1:0] mode,
                                          logic sink, logic chip_dead);
    pfs_item_t t;
    t.op = op;
    t.bus_mv = bus;
    t.battery_mv = bat;
    t.chip_faults = faults;
    t.thermal_lock = thermal;
    t.work_mode = mode;
    t.sink_attached = sink;
    t.chip_dead_battery = chip_dead;
    return t;
  endfunction

  function automatic logic [15:0] volts_below(logic [15:0] thr);
    if (thr == 16'd0) return 16'd0;
    if ($urandom_range(0, 1) == 0) return thr - 16'd1;
    return 16'($urandom_range(0, thr - 1));
  endfunction

  function automatic logic [15:0] volts_above(logic [15:0] thr);
    if (thr == 16'hFFFF) return thr;
    if ($urandom_range(0, 1) == 0) return thr + 16'd1;
    return 16'($urandom_range(thr + 1, 65535));
  endfunction

  function automatic logic [15:0] volts_any(logic [15:0] thr);
    case ($urandom_range(0, 3))
      0: return volts_below(thr);
      1: return volts_above(thr);
      2: return thr;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] fault_bits();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'($urandom) & 8'h2A;
      2: return 8'($urandom);
      default: return 8'h01 << $urandom_range(0, 7);
    endcase
  endfunction

  function automatic pfs_item_t random_tick(logic [1:0] op);
    pfs_item_t t;
    t.op = op;
    t.bus_mv = volts_any($urandom_range(0, 1) ? regs.bus_ov_mv : regs.bus_uv_mv);
    t.battery_mv = volts_any($urandom_range(0, 1) ? regs.bat_low_mv : regs.bat_recover_mv);
    t.chip_faults = fault_bits();
    t.thermal_lock = ($urandom_range(0, 7) == 0);
    t.work_mode = 2'($urandom_range(0, 3));
    t.sink_attached = 1'($urandom);
    t.chip_dead_battery = 1'($urandom);
    return t;
  endfunction

  task automatic run_random(int n);
    int target;
    int len;
    pfs_item_t t;
    target = accepted + n;
    while (accepted < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          t = random_tick(2'($urandom_range(0, 3)));
          if ($urandom_range(0, 2) == 0) begin
            t.bus_mv = 16'($urandom);
            t.battery_mv = 16'($urandom);
          end
          send_tick(t);
        end
        3, 4, 5: begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            t = random_tick(OP_VBUS);
            t.work_mode = ($urandom_range(0, 11) == 0) ? MODE_UNDEF : MODE_DISCHG;
            t.sink_attached = ($urandom_range(0, 11) != 0);
            t.bus_mv = ($urandom_range(0, 7) == 0) ? volts_above(regs.bus_uv_mv)
                                                    : volts_below(regs.bus_uv_mv);
            send_tick(t);
          end
          send_tick(random_tick(OP_PROTECT));
        end
        6, 7, 8: begin
          len = $urandom_range(1, 16);
          repeat (len) begin
            t = random_tick(OP_PROTECT);
            if ($urandom_range(0, 9) != 0) t.battery_mv = volts_below(regs.bat_low_mv);
            if ($urandom_range(0, 2) == 0) begin
              t.chip_faults = 8'h00;
              t.thermal_lock = 1'b0;
            end
            send_tick(t);
          end
          repeat ($urandom_range(1, 2)) begin
            t = random_tick(OP_RECOVER);
            t.battery_mv = volts_any(regs.bat_recover_mv);
            t.chip_dead_battery = ($urandom_range(0, 3) == 0);
            send_tick(t);
          end
        end
        default: begin
          t = random_tick(($urandom_range(0, 1) == 0) ? OP_NONE : 2'($urandom_range(0, 2)));
          t.work_mode = MODE_UNDEF;
          send_tick(t);
        end
      endcase
    end
  endtask

  task automatic test_status_merge();
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, MODE_UNDEF, 1'b1, 1'b1));
    send_tick(make_tick(OP_PROTECT, 16'd20000, 16'd3000, 8'h00, 1'b0, MODE_CHARGE, 1'b0, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd20001, 16'd3000, 8'h00, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_NONE, 16'h5555, 16'hAAAA, 8'h5A, 1'b1, MODE_UNDEF, 1'b1, 1'b1));
    send_tick(make_tick(OP_RECOVER, 16'hAAAA, 16'h5555, 8'hA5, 1'b0, MODE_DISCHG, 1'b0, 1'b0));
  endtask

  task automatic test_non_locking_faults();
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h2A, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h0A, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h40, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h40, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
  endtask

  task automatic test_undervoltage();
    repeat (5) begin
      send_tick(make_tick(OP_VBUS, 16'd4399, 16'hFFFF, 8'h00, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    end
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_VBUS, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_UNDEF, 1'b1, 1'b0));
  endtask

  task automatic test_zero_thresholds();
    program_regs(16'd20000, 16'd3000, 16'd0, 16'd4400, 16'd0, 16'd3300);
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'd0, 8'h00, 1'b0, MODE_CHARGE, 1'b0, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'd0, 8'h00, 1'b0, MODE_CHARGE, 1'b0, 1'b0));
    send_tick(make_tick(OP_PROTECT, 16'd0, 16'd0, 8'h00, 1'b0, MODE_DISCHG, 1'b0, 1'b0));
    send_tick(make_tick(OP_RECOVER, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_OTHER, 1'b0, 1'b1));
    send_tick(make_tick(OP_RECOVER, 16'd0, 16'd3300, 8'h00, 1'b0, MODE_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(OP_RECOVER, 16'd0, 16'd3301, 8'h00, 1'b0, MODE_OTHER, 1'b0, 1'b0));
    send_tick(make_tick(OP_VBUS, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_DISCHG, 1'b1, 1'b0));
    send_tick(make_tick(OP_VBUS, 16'd0, 16'hFFFF, 8'h00, 1'b0, MODE_DISCHG, 1'b0, 1'b0));
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_cycles = 60;
    repeat (30) send_tick(random_tick(2'($urandom_range(0, 3))));
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_configs();
    program_regs(RST_BUS_OV_MV, RST_BAT_LOW_MV, 16'(RST_BAT_LOW_TCK), RST_BUS_UV_MV,
                 16'(RST_BUS_UV_TCK), RST_BAT_RECOV_MV);
    run_random(240);
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(240);
    program_regs(16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'd7, 16'hFFFF);
    run_random(240);
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    run_random(240);
    program_regs(16'($urandom), 16'($urandom), 16'd1, 16'($urandom), 16'd1, 16'($urandom));
    run_random(240);
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(300);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    offer = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_cycles = 0;
    accepted = 0;
    fails = 0;
    shadow = '0;
    regs.bus_ov_mv = RST_BUS_OV_MV;
    regs.bat_low_mv = RST_BAT_LOW_MV;
    regs.bat_low_ticks = RST_BAT_LOW_TCK;
    regs.bus_uv_mv = RST_BUS_UV_MV;
    regs.bus_uv_ticks = RST_BUS_UV_TCK;
    regs.bat_recover_mv = RST_BAT_RECOV_MV;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_status_merge();
    test_non_locking_faults();
    test_undervoltage();
    test_zero_thresholds();
    test_backpressure();
    test_random_configs();
    test_steady_stream();

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/pfs_pkg.sv
design/pfs_core.sv
design/power_fault_supervisor_unit.sv
sim/power_fault_supervisor_unit_tb.sv
